// File: design/wavetable_waveshaper_normalizer_core_macros.svh
// ----------------------------------------------------------------------------
// wavetable waveshaper normalizer assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_WAVESHAPER_NORMALIZER_CORE_MACROS_SVH
`define WAVETABLE_WAVESHAPER_NORMALIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define WWN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define WWN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define WWN_ASSERT(lbl, prop, msg)
`define WWN_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: design/wwn_pkg.sv
// ----------------------------------------------------------------------------
// wwn_pkg
// shared widths, codes and control types of the waveshaper normalizer
// ----------------------------------------------------------------------------
package wwn_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MODE_W     = 2;
  localparam int GAIN_W     = 8;
  localparam int THR_W      = 16;
  localparam int AMP_W      = 15;
  localparam int LEN_W      = 11;
  localparam int STEP_W     = 26;
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = LEN_W + FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;
  localparam int PROD_W     = 24;
  localparam int DVD_W      = 38;
  localparam int DVS_W      = 24;

  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOFT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FOLD = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd5;

  localparam logic [MODE_W-1:0] RST_MODE = MODE_PASS;
  localparam logic [GAIN_W-1:0] RST_GAIN = 8'd1;
  localparam logic [THR_W-1:0]  RST_THR  = 16'd26214;
  localparam logic [AMP_W-1:0]  RST_AMP  = 15'd16384;
  localparam logic [LEN_W-1:0]  RST_LEN  = 11'd1024;
  localparam logic [STEP_W-1:0] RST_STEP = 26'd139810;

  typedef enum logic [1:0] {
    DIV_SHAPE = 2'd0,
    DIV_IDX   = 2'd1,
    DIV_WRAP  = 2'd2,
    DIV_NORM  = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    logic     div_start;
    div_sel_e div_sel;
    logic     mem_we;
    logic     mem_re;
    logic     phase_en;
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic need_div;
    logic peak_zero;
    logic div_busy;
    logic div_done;
  } stat_t;

endpackage

// File: design/wwn_divider.sv
// ----------------------------------------------------------------------------
// wwn_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wwn_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wwn_pkg::DVD_W-1:0] dividend_i,
  input  logic [wwn_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [wwn_pkg::DVD_W-1:0] quotient_o,
  output logic [wwn_pkg::DVS_W-1:0] remainder_o
);
  import wwn_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] div_q, div_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: design/wwn_datapath.sv
// ----------------------------------------------------------------------------
// wwn_datapath
// config registers, shaping, table store, phase accumulator and output
// ----------------------------------------------------------------------------
module wwn_datapath #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [wwn_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wwn_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                command_i,
  input  logic signed [wwn_pkg::SAMPLE_W-1:0] table_sample_i,
  input  logic                                first_sample_i,
  input  wwn_pkg::ctrl_t                      ctrl_i,
  output wwn_pkg::stat_t                      stat_o,
  output logic signed [wwn_pkg::SAMPLE_W-1:0] audio_sample_o
);
  import wwn_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int PTR_W = $clog2(TABLE_SIZE + 1);
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((TABLE_SIZE > (2 ** LEN_W) - 1) ? (2 ** LEN_W) - 1 : TABLE_SIZE);

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [39:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[SAMPLE_W-1:0];
    return r;
  endfunction

  logic [MODE_W-1:0] mode_q;
  logic [GAIN_W-1:0] gain_q;
  logic [THR_W-1:0]  thr_q;
  logic [AMP_W-1:0]  amp_q;
  logic [LEN_W-1:0]  tlen_q;
  logic [STEP_W-1:0] step_q;

  logic [PTR_W-1:0]   ptr_q;
  logic [SAMPLE_W-1:0] peak_q;
  logic [PHASE_W-1:0] phase_q;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [PROD_W-1:0]   y_q;
  logic signed [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0]        rd_q;
  logic signed [SAMPLE_W-1:0] audio_q;
  logic [SAMPLE_W-1:0]        mem [TABLE_SIZE];

  logic [LEN_W-1:0]    len_eff;
  logic                restart;
  logic [PROD_W-1:0]   y_abs;
  logic                over;
  logic signed [PROD_W:0] d;
  logic [PROD_W-1:0]   d_abs;
  logic [PHASE_W:0]    sum;
  logic [SAMPLE_W-1:0] ent_abs;
  logic [AMP_W+SAMPLE_W-1:0] norm_num;

  logic               div_start;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               div_busy, div_done;
  logic [DVD_W-1:0]   quo;
  logic [DVS_W-1:0]   rem;

  logic signed [19:0] fold_a;
  logic [19:0]        fold_a_abs;
  logic signed [19:0] fold_f;
  logic [SAMPLE_W-1:0] soft_q;
  logic signed [SAMPLE_W-1:0] ent;
  logic [SAMPLE_W-1:0] ent_mag;
  logic signed [39:0] norm_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RST_MODE;
      gain_q <= RST_GAIN;
      thr_q  <= RST_THR;
      amp_q  <= RST_AMP;
      tlen_q <= RST_LEN;
      step_q <= RST_STEP;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        REG_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_THR:  thr_q  <= cfg_data_i[THR_W-1:0];
        REG_AMP:  amp_q  <= cfg_data_i[AMP_W-1:0];
        REG_LEN:  tlen_q <= cfg_data_i[LEN_W-1:0];
        REG_STEP: step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = (tlen_q == '0) ? LEN_W'(1) : tlen_q;
    if (32'(tlen_q) > TABLE_SIZE) len_eff = LEN_CAP;
  end

  assign restart  = ctrl_i.capture && (command_i == CMD_LOAD) && first_sample_i;
  assign prod     = $signed({1'b0, gain_q}) * sample_q;
  assign y_abs    = y_q[PROD_W-1] ? PROD_W'(-y_q) : PROD_W'(y_q);
  assign over     = y_abs > PROD_W'(thr_q);
  assign d        = $signed({y_q[PROD_W-1], y_q}) - $signed({9'b0, thr_q});
  assign d_abs    = d[PROD_W] ? PROD_W'(-d) : PROD_W'(d);
  assign sum      = {1'b0, phase_q} + (PHASE_W + 1)'(step_q);
  assign ent_abs  = rd_q[SAMPLE_W-1] ? (~rd_q + SAMPLE_W'(1)) : rd_q;
  assign norm_num = amp_q * ent_abs;

  always_comb begin
    dvd = '0;
    dvs = '0;
    case (ctrl_i.div_sel)
      DIV_SHAPE: begin
        if (mode_q == MODE_SOFT) begin
          dvd = DVD_W'(y_abs) << 15;
          dvs = DVS_W'(y_abs) + DVS_W'(32768);
        end else begin
          dvd = DVD_W'(d_abs);
          dvs = DVS_W'({thr_q, 2'b00});
        end
      end
      DIV_IDX: begin
        dvd = DVD_W'(phase_q[PHASE_W-1:FRAC_W]);
        dvs = DVS_W'(len_eff);
      end
      DIV_WRAP: begin
        dvd = DVD_W'(sum[PHASE_W:FRAC_W]);
        dvs = DVS_W'(len_eff);
      end
      DIV_NORM: begin
        dvd = DVD_W'(norm_num);
        dvs = DVS_W'(peak_q);
      end
      default: ;
    endcase
  end

  assign div_start = ctrl_i.div_start;

  wwn_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo),
    .remainder_o(rem)
  );

  // shaped entry from the divider result, the product or the captured sample
  always_comb begin
    fold_a     = $signed({2'b0, rem[17:0]}) - $signed({3'b0, thr_q, 1'b0});
    fold_a_abs = fold_a[19] ? 20'(-fold_a) : 20'(fold_a);
    fold_f     = $signed(fold_a_abs) - $signed({4'b0, thr_q});
    soft_q     = quo[SAMPLE_W-1:0];
    case (mode_q)
      MODE_SOFT: ent = y_q[PROD_W-1] ? -$signed(soft_q) : $signed(soft_q);
      MODE_FOLD: begin
        if (!over) ent = sat16(40'(y_q));
        else if (thr_q == '0) ent = '0;
        else ent = sat16(40'(fold_f));
      end
      default: ent = sample_q;
    endcase
    ent_mag = ent[SAMPLE_W-1] ? (~ent + SAMPLE_W'(1)) : ent;
  end

  always_comb begin
    norm_val = $signed({2'b0, quo});
    if (rd_q[SAMPLE_W-1]) norm_val = -norm_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      peak_q  <= '0;
      phase_q <= '0;
    end else if (restart) begin
      ptr_q   <= '0;
      peak_q  <= '0;
      phase_q <= '0;
    end else begin
      if (ctrl_i.mem_we) begin
        ptr_q <= ptr_q + PTR_W'(1);
        if (ent_mag > peak_q) peak_q <= ent_mag;
      end
      if (ctrl_i.phase_en) phase_q <= {rem[LEN_W-1:0], sum[FRAC_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) sample_q <= table_sample_i;
    if (ctrl_i.mul_en) y_q <= prod;
    if (ctrl_i.out_load) audio_q <= (peak_q == '0) ? '0 : sat16(norm_val);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_we) mem[ptr_q[IDX_W-1:0]] <= ent;
    if (ctrl_i.mem_re) rd_q <= mem[rem[IDX_W-1:0]];
  end

  assign stat_o.full      = ptr_q == PTR_W'(TABLE_SIZE);
  assign stat_o.need_div  = (mode_q == MODE_SOFT) ||
                            ((mode_q == MODE_FOLD) && over && (thr_q != '0));
  assign stat_o.peak_zero = peak_q == '0;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.div_done  = div_done;
  assign audio_sample_o   = audio_q;

endmodule

// File: design/wwn_controller.sv
// ----------------------------------------------------------------------------
// wwn_controller
// sequencer for load and tick transactions and the output register valid
// ----------------------------------------------------------------------------
module wwn_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           command_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  wwn_pkg::stat_t stat_i,
  output wwn_pkg::ctrl_t ctrl_o
);
  import wwn_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_LMUL   = 11'b000_0000_0010,
    S_LSHAPE = 11'b000_0000_0100,
    S_LDIV   = 11'b000_0000_1000,
    S_LWRITE = 11'b000_0001_0000,
    S_TIDX   = 11'b000_0010_0000,
    S_TREAD  = 11'b000_0100_0000,
    S_TWRAP  = 11'b000_1000_0000,
    S_TNORM  = 11'b001_0000_0000,
    S_TNDIV  = 11'b010_0000_0000,
    S_TOUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.div_sel = DIV_SHAPE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctrl_o.capture = 1'b1;
          if (command_i == CMD_TICK) begin
            ctrl_o.div_start = 1'b1;
            ctrl_o.div_sel   = DIV_IDX;
            state_d = S_TIDX;
          end else begin
            state_d = S_LMUL;
          end
        end
      end
      S_LMUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d = S_LSHAPE;
      end
      S_LSHAPE: begin
        if (stat_i.full) begin
          state_d = S_IDLE;
        end else if (stat_i.need_div) begin
          ctrl_o.div_start = 1'b1;
          state_d = S_LDIV;
        end else begin
          state_d = S_LWRITE;
        end
      end
      S_LDIV: begin
        if (stat_i.div_done) state_d = S_LWRITE;
      end
      S_LWRITE: begin
        ctrl_o.mem_we = 1'b1;
        state_d = S_IDLE;
      end
      S_TIDX: begin
        if (stat_i.div_done) state_d = S_TREAD;
      end
      S_TREAD: begin
        ctrl_o.mem_re    = 1'b1;
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_sel   = DIV_WRAP;
        state_d = S_TWRAP;
      end
      S_TWRAP: begin
        ctrl_o.div_sel = DIV_WRAP;
        if (stat_i.div_done) state_d = S_TNORM;
      end
      S_TNORM: begin
        ctrl_o.phase_en = 1'b1;
        ctrl_o.div_sel  = DIV_WRAP;
        if (stat_i.peak_zero) begin
          state_d = S_TOUT;
        end else begin
          state_d = S_TNDIV;
        end
      end
      S_TNDIV: begin
        ctrl_o.div_sel = DIV_NORM;
        if (stat_i.div_done) state_d = S_TOUT;
      end
      S_TOUT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_TNORM && !stat_i.peak_zero) begin
      ctrl_o.div_start = 1'b1;
      ctrl_o.div_sel   = DIV_NORM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

`include "wavetable_waveshaper_normalizer_core_macros.svh"

  `WWN_ASSERT(a_start_not_busy, ctrl_o.div_start |-> !stat_i.div_busy, "divider restarted")
  `WWN_ASSERT_NEXT(a_accept_blocks, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `WWN_ASSERT(a_no_overwrite, ctrl_o.out_load |-> (!out_valid_q || out_ready_i), "result lost")
  `WWN_ASSERT(a_write_not_full, ctrl_o.mem_we |-> !stat_i.full, "write into full table")

endmodule

// File: design/wavetable_waveshaper_normalizer_core.sv
// ----------------------------------------------------------------------------
// wavetable_waveshaper_normalizer_core
// waveshaping wavetable loader with peak-normalized phase playback
// ----------------------------------------------------------------------------
// input channel (in_valid_i/in_ready_o): command_i 0 loads table_sample_i
// into the next table entry after shaping, first_sample_i restarts pointer,
// peak and phase; command_i 1 is a tick that yields one audio_sample_o on
// the output channel (out_valid_o/out_ready_i). loads give no result.
// config writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always taken.
// one transaction is in flight at a time. a load goes through multiply,
// shape and write, skips the write when the table is full and waits on
// the bit-serial divider with soft clip or foldback. a tick takes 3
// divider passes (index wrap, phase wrap, normalize) and skips the
// normalize pass while the peak is zero.
// the result sits in an output register; the next transaction is accepted
// while it waits, and a stalled receiver holds only the following tick.
// reset clears pointer, peak, phase and config to defaults; table contents
// are undefined until loaded.
// ----------------------------------------------------------------------------
module wavetable_waveshaper_normalizer_core #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wwn_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wwn_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic signed [wwn_pkg::SAMPLE_W-1:0] table_sample_i,
  input  logic                                first_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wwn_pkg::SAMPLE_W-1:0] audio_sample_o
);
  import wwn_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  wwn_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  wwn_datapath #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .table_sample_i(table_sample_i),
    .first_sample_i(first_sample_i),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .audio_sample_o(audio_sample_o)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives loads and ticks into the waveshaper normalizer core, predicts every
// audio sample from its own model of the shaped table, peak and phase, and
// checks each output transaction in order under random idling and stalls
// ----------------------------------------------------------------------------
module tb_top;
  import wwn_pkg::*;

  localparam int TBL_DEPTH   = 1024;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 200;
  localparam int ITEM_TARGET = 1250;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  command_i = CMD_LOAD;
  logic signed [15:0]    table_sample_i = '0;
  logic                  first_sample_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [15:0]    audio_sample_o;

  wavetable_waveshaper_normalizer_core #(.TABLE_SIZE(TBL_DEPTH)) dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0]    shaped_mem [TBL_DEPTH];
  int unsigned           peak_mag;
  int unsigned           load_ptr;
  int unsigned           loaded_hwm;
  longint unsigned       phase_acc;
  logic [MODE_W-1:0]     mode_q;
  logic [GAIN_W-1:0]     gain_q;
  logic [THR_W-1:0]      thr_q;
  logic [AMP_W-1:0]      amp_q;
  logic [LEN_W-1:0]      len_q;
  logic [STEP_W-1:0]     step_q;

  logic signed [15:0]    audio_expected [$];
  int                    errors = 0;
  int                    cycles = 0;
  int                    burst_left;
  int                    stall_mode = 0;
  int                    sent_items;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint shape_sample(longint s);
    longint y;
    longint t;
    longint r;
    y = longint'(gain_q) * s;
    t = longint'(thr_q);
    if (mode_q == MODE_SOFT) return sat16((y * 32768) / (32768 + mag(y)));
    if (mode_q == MODE_FOLD) begin
      if (y > t || y < -t) begin
        if (t == 0) return 0;
        r = (y - t) % (4 * t);
        y = mag(mag(r) - 2 * t) - t;
      end
      return sat16(y);
    end
    return s;
  endfunction

  function automatic longint unsigned wrap_len();
    if (len_q == 0) return 1;
    if (len_q > TBL_DEPTH) return TBL_DEPTH;
    return len_q;
  endfunction

  function automatic int unsigned tick_index();
    return int'((phase_acc >> 16) % wrap_len());
  endfunction

  function automatic void predict(bit cmd, logic signed [15:0] smp, bit first);
    longint e;
    longint v;
    if (cmd == CMD_LOAD) begin
      if (first) begin
        load_ptr = 0;
        peak_mag = 0;
        phase_acc = 0;
      end
      if (load_ptr < TBL_DEPTH) begin
        e = shape_sample(longint'(smp));
        shaped_mem[load_ptr] = e[15:0];
        if (mag(e) > peak_mag) peak_mag = int'(mag(e));
        load_ptr++;
        if (load_ptr > loaded_hwm) loaded_hwm = load_ptr;
      end
    end else begin
      v = 0;
      if (peak_mag != 0)
        v = sat16((longint'(amp_q) * longint'(shaped_mem[tick_index()])) / longint'(peak_mag));
      phase_acc = (phase_acc + step_q) % (wrap_len() << 16);
      audio_expected.insert(audio_expected.size(), v[15:0]);
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // output side: stall pattern and checking
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("status: fail");
      $finish;
    end
    if (cycles % 700 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (audio_expected.size() == 0) report("unexpected audio_sample", audio_sample_o, 0);
      else begin
        if (audio_sample_o !== audio_expected[0])
          report("audio_sample", audio_sample_o, audio_expected[0]);
        void'(audio_expected.pop_front());
      end
    end
  end

  task automatic send_item(bit cmd, logic signed [15:0] smp, bit first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    table_sample_i <= smp;
    first_sample_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    predict(cmd, smp, first);
    sent_items++;
  endtask

  task automatic load(logic signed [15:0] smp, bit first = 1'b0);
    send_item(CMD_LOAD, smp, first);
  endtask

  task automatic tick();
    send_item(CMD_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // stop sending and let every pending transaction finish
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (audio_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MODE: mode_q = MODE_W'(val);
      REG_GAIN: gain_q = GAIN_W'(val);
      REG_THR:  thr_q  = THR_W'(val);
      REG_AMP:  amp_q  = AMP_W'(val);
      REG_LEN:  len_q  = LEN_W'(val);
      REG_STEP: step_q = STEP_W'(val);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    tick();
    load(16'sh7fff, 1'b1);
    load(-16'sh8000);
    load(0);
    load(1);
    load(-1);
    repeat (3) tick();
    drain();
  endtask

  task automatic test_shaping_modes();
    logic [MODE_W-1:0] m;
    for (int i = 0; i < 4; i++) begin
      m = MODE_W'(i);
      write_reg(REG_MODE, m);
      write_reg(REG_GAIN, (i == 3) ? 0 : 255);
      write_reg(REG_THR, (i == 2) ? 1000 : 32768);
      write_reg(REG_LEN, 4);
      write_reg(REG_STEP, 1 << 16);
      load(16'sh7fff, 1'b1);
      load(-16'sh8000);
      load(300);
      load(-7);
      repeat (2) tick();
      drain();
    end
  endtask

  task automatic test_length_phase();
    write_reg(REG_MODE, MODE_PASS);
    write_reg(REG_AMP, 32767);
    write_reg(REG_LEN, 0);
    write_reg(REG_STEP, 26'h3ffffff);
    load(-16'sh8000, 1'b1);
    load(16'sh7fff);
    repeat (2) tick();
    drain();
    write_reg(REG_LEN, 2047);
    repeat (2) tick();
    drain();
    // restart with a small peak so a stale large entry saturates
    write_reg(REG_LEN, 2);
    write_reg(REG_STEP, 1 << 16);
    load(5, 1'b1);
    repeat (2) tick();
    drain();
    write_reg(REG_AMP, 0);
    repeat (2) tick();
    drain();
  endtask

  task automatic test_table_full();
    write_reg(REG_MODE, MODE_PASS);
    write_reg(REG_AMP, 12345);
    write_reg(REG_LEN, 1024);
    write_reg(REG_STEP, 26'd3000000);
    load(16'($urandom), 1'b1);
    repeat (TBL_DEPTH) load(16'($urandom));
    repeat (8) tick();
    // everything is written now: pause until all results are back
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (audio_expected.size() != 0) @(posedge clk_i);
    repeat (8) tick();
    drain();
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      1: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random_playback();
    int n;
    while (sent_items < ITEM_TARGET) begin
      write_reg(REG_MODE, $urandom_range(0, 3));
      write_reg(REG_GAIN, $urandom_range(0, 1) ? $urandom_range(0, 255)
                                               : ($urandom_range(0, 1) ? 0 : 255));
      write_reg(REG_THR, $urandom_range(0, 3) ? $urandom_range(1, 32768)
                                              : ($urandom_range(0, 1) ? 1 : 32768));
      write_reg(REG_AMP, $urandom_range(0, 3) ? $urandom_range(0, 32767) : 32767);
      write_reg(REG_LEN, $urandom_range(0, 4) ? $urandom_range(1, 40) : $urandom_range(0, 2047));
      write_reg(REG_STEP, $urandom_range(0, 2) ? $urandom_range(0, 40 << 16) : $urandom);
      load(rand_sample(), 1'b1);
      n = $urandom_range(1, 40);
      repeat (n) load(rand_sample());
      repeat ($urandom_range(5, 40)) begin
        if (tick_index() < loaded_hwm && $urandom_range(0, 5) != 0) tick();
        else load(rand_sample(), ($urandom_range(0, 15) == 0));
      end
      drain();
    end
  endtask

  initial begin
    burst_left = 0;
    sent_items = 0;
    peak_mag = 0;
    load_ptr = 0;
    loaded_hwm = 0;
    phase_acc = 0;
    mode_q = RST_MODE;
    gain_q = RST_GAIN;
    thr_q  = RST_THR;
    amp_q  = RST_AMP;
    len_q  = RST_LEN;
    step_q = RST_STEP;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_shaping_modes();
    test_length_phase();
    test_table_full();
    test_random_playback();
    drain();
    if (audio_expected.size() != 0) report("missing audio_sample count", 0, audio_expected.size());
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
